[hw/rtl/dwalu_pkg.sv]
`default_nettype none

package dwalu_pkg;

    localparam int CMD_W = 4;
    localparam int AMT_W = 7;
    localparam int WORD_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM = 4'd4;
    localparam logic [CMD_W-1:0] CMD_AND = 4'd5;
    localparam logic [CMD_W-1:0] CMD_OR  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_XOR = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NOT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SHL = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SHR = 4'd10;
    localparam logic [CMD_W-1:0] CMD_INC = 4'd11;
    localparam logic [CMD_W-1:0] CMD_DEC = 4'd12;
    localparam logic [CMD_W-1:0] CMD_CMP = 4'd13;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [AMT_W-1:0] t_amount;
    typedef logic [WORD_W-1:0] t_word;

endpackage

`default_nettype wire

[hw/rtl/double_width_integer_alu.sv]
`default_nettype none

// Unsigned ALU on numbers of 2*HALF_WIDTH bits, each given as a high and a low word.
// A request is taken when start is high and busy is low; the single result then
// appears for exactly one cycle with o_valid high and cannot be held off, so it
// must be captured on that cycle. Add, sub, inc, dec, compare, mul, div and rem go
// through one shared adder/subtractor and shifts through a one-bit shifter, under a
// small sequencer; logic ops are computed directly. Mul, div and rem do one
// shift-add or shift-subtract step per bit; shl and shr shift one bit per cycle,
// or give zero when the amount is the full width or more. A divide by zero skips
// the steps. Words wider than 32 bits give only their low 32 bits out.
module double_width_integer_alu #(
    parameter int HALF_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dwalu_pkg::t_cmd    i_command,
    input  wire dwalu_pkg::t_word   i_a_high,
    input  wire dwalu_pkg::t_word   i_a_low,
    input  wire dwalu_pkg::t_word   i_b_high,
    input  wire dwalu_pkg::t_word   i_b_low,
    input  wire dwalu_pkg::t_amount i_shift_amount,
    output logic                  o_valid,
    output dwalu_pkg::t_word      o_result_high,
    output dwalu_pkg::t_word      o_result_low,
    output logic                  o_is_equal,
    output logic                  o_is_greater,
    output logic                  o_is_lesser,
    output logic                  o_is_zero,
    output logic                  o_divide_by_zero
);

    import dwalu_pkg::*;

    localparam int FULL = 2 * HALF_WIDTH;
    localparam int CW = $clog2(FULL + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]      r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [FULL-1:0] r_a, n_a;
    logic [FULL-1:0] r_b, n_b;
    logic [FULL-1:0] r_acc, n_acc;
    logic [FULL-1:0] r_q, n_q;
    logic [FULL-1:0] r_res, n_res;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_big, n_big;
    logic            r_eq, n_eq;
    logic            r_gt, n_gt;
    logic            r_lt, n_lt;
    logic            r_zr, n_zr;
    logic            r_dz, n_dz;

    logic [63:0]     ah_ext, al_ext, bh_ext, bl_ext;
    logic [FULL-1:0] a_in, b_in;
    logic            amt_big;

    logic [FULL-1:0] op_x, op_y, rem_sh;
    logic            op_sub, take;
    logic [FULL:0]   sum;
    logic [FULL-1:0] mul_acc, div_rem, div_quo;
    logic            run_done;

    logic [63:0]     res_hi_ext, res_lo_ext;

    // operand words masked to the configured word width
    assign ah_ext = {32'b0, i_a_high};
    assign al_ext = {32'b0, i_a_low};
    assign bh_ext = {32'b0, i_b_high};
    assign bl_ext = {32'b0, i_b_low};
    assign a_in = {ah_ext[HALF_WIDTH-1:0], al_ext[HALF_WIDTH-1:0]};
    assign b_in = {bh_ext[HALF_WIDTH-1:0], bl_ext[HALF_WIDTH-1:0]};
    assign amt_big = ({1'b0, i_shift_amount} >= 8'(FULL));

    // shared adder/subtractor
    assign rem_sh = {r_acc[FULL-2:0], r_a[FULL-1]};

    always_comb begin
        op_x = r_a;
        op_y = r_b;
        op_sub = 1'b0;
        case (r_cmd)
            CMD_SUB, CMD_CMP: begin
                op_sub = 1'b1;
            end
            CMD_MUL: begin
                op_x = r_acc;
                op_y = r_q;
            end
            CMD_DIV, CMD_REM: begin
                op_x = rem_sh;
                op_sub = 1'b1;
            end
            CMD_INC: begin
                op_y = FULL'(1);
            end
            CMD_DEC: begin
                op_y = FULL'(1);
                op_sub = 1'b1;
            end
            default: begin
                op_sub = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, op_x} + {1'b0, op_sub ? ~op_y : op_y} + (FULL + 1)'(op_sub);

    assign take = r_acc[FULL-1] | sum[FULL];
    assign div_rem = take ? sum[FULL-1:0] : rem_sh;
    assign div_quo = {r_q[FULL-2:0], take};
    assign mul_acc = r_b[0] ? sum[FULL-1:0] : r_acc;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_q = r_q;
        n_res = r_res;
        n_cnt = r_cnt;
        n_big = r_big;
        n_eq = r_eq;
        n_gt = r_gt;
        n_lt = r_lt;
        n_zr = r_zr;
        n_dz = r_dz;
        run_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                    n_cmd = i_command;
                    n_a = a_in;
                    n_b = b_in;
                    n_acc = (i_command == CMD_SHL || i_command == CMD_SHR) ? a_in : '0;
                    n_q = (i_command == CMD_MUL) ? a_in : '0;
                    n_cnt = (i_command == CMD_SHL || i_command == CMD_SHR) ?
                            CW'(i_shift_amount) : CW'(FULL);
                    n_big = amt_big;
                    n_eq = 1'b0;
                    n_gt = 1'b0;
                    n_lt = 1'b0;
                    n_zr = 1'b0;
                    n_dz = (i_command == CMD_DIV || i_command == CMD_REM) && (b_in == '0);
                end
            end
            S_RUN: begin
                case (r_cmd)
                    CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
                        n_res = sum[FULL-1:0];
                        run_done = 1'b1;
                    end
                    CMD_MUL: begin
                        n_acc = mul_acc;
                        n_q = {r_q[FULL-2:0], 1'b0};
                        n_b = {1'b0, r_b[FULL-1:1]};
                        n_cnt = r_cnt - CW'(1);
                        n_res = mul_acc;
                        run_done = (r_cnt == CW'(1));
                    end
                    CMD_DIV, CMD_REM: begin
                        if (r_dz) begin
                            n_res = (r_cmd == CMD_DIV) ? '1 : r_a;
                            run_done = 1'b1;
                        end else begin
                            n_acc = div_rem;
                            n_q = div_quo;
                            n_a = {r_a[FULL-2:0], 1'b0};
                            n_cnt = r_cnt - CW'(1);
                            n_res = (r_cmd == CMD_DIV) ? div_quo : div_rem;
                            run_done = (r_cnt == CW'(1));
                        end
                    end
                    CMD_AND: begin
                        n_res = r_a & r_b;
                        run_done = 1'b1;
                    end
                    CMD_OR: begin
                        n_res = r_a | r_b;
                        run_done = 1'b1;
                    end
                    CMD_XOR: begin
                        n_res = r_a ^ r_b;
                        run_done = 1'b1;
                    end
                    CMD_NOT: begin
                        n_res = ~r_a;
                        run_done = 1'b1;
                    end
                    CMD_SHL, CMD_SHR: begin
                        if (r_big) begin
                            n_res = '0;
                            run_done = 1'b1;
                        end else if (r_cnt == '0) begin
                            n_res = r_acc;
                            run_done = 1'b1;
                        end else begin
                            n_acc = (r_cmd == CMD_SHL) ? {r_acc[FULL-2:0], 1'b0} :
                                                         {1'b0, r_acc[FULL-1:1]};
                            n_cnt = r_cnt - CW'(1);
                        end
                    end
                    CMD_CMP: begin
                        n_res = '0;
                        n_eq = (r_a == r_b);
                        n_lt = ~sum[FULL];
                        n_gt = sum[FULL] & (r_a != r_b);
                        n_zr = (r_a == '0);
                        run_done = 1'b1;
                    end
                    default: begin
                        n_res = '0;
                        run_done = 1'b1;
                    end
                endcase
                if (run_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
        r_q <= n_q;
        r_res <= n_res;
        r_cnt <= n_cnt;
        r_big <= n_big;
        r_eq <= n_eq;
        r_gt <= n_gt;
        r_lt <= n_lt;
        r_zr <= n_zr;
        r_dz <= n_dz;
    end

    // outputs
    assign res_hi_ext = 64'(r_res[FULL-1:HALF_WIDTH]);
    assign res_lo_ext = 64'(r_res[HALF_WIDTH-1:0]);

    assign busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_result_high = res_hi_ext[WORD_W-1:0];
    assign o_result_low = res_lo_ext[WORD_W-1:0];
    assign o_is_equal = r_eq;
    assign o_is_greater = r_gt;
    assign o_is_lesser = r_lt;
    assign o_is_zero = r_zr;
    assign o_divide_by_zero = r_dz;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but unit not busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("unit still busy after result strobe");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> (r_cmd == CMD_DIV || r_cmd == CMD_REM))
        else $error("divide by zero flagged on a non-divide request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cmd == CMD_CMP) |-> $onehot({o_is_equal, o_is_greater, o_is_lesser}))
        else $error("compare flags not exclusive");

endmodule

`default_nettype wire
